// File: sv/oat_pkg.sv
package oat_pkg;

  // table geometry
  localparam int DEPTH     = 64;
  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // port field widths
  localparam int OP_W      = 3;
  localparam int POS_W     = 8;
  localparam int STAT_W    = 2;
  localparam int OUT_IDX_W = 6;
  localparam int OUT_CNT_W = 7;

  // width used to compare position against counts
  localparam int CMP_W     = (POS_W > CNT_W) ? POS_W : CNT_W;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ADD       = 3'd0,
    OP_FIND      = 3'd1,
    OP_REM_KEY   = 3'd2,
    OP_REM_IDX   = 3'd3,
    OP_GET_NTH   = 3'd4,
    OP_GET_IDX   = 3'd5,
    OP_REKEY_KEY = 3'd6,
    OP_REKEY_IDX = 3'd7
  } op_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic    load;
    logic    scan_init;
    logic    scan_step;
    logic    shift_init;
    logic    shift_step;
    logic    hit_from_pos;
    logic    wr_add;
    logic    wr_key;
    logic    fetch;
    logic    dec_count;
    logic    out_load;
    status_t out_status;
  } oat_cmd_t;

  // datapath to controller status
  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic pos_oob;
    logic hit;
    logic miss;
    logic shift_done;
    logic out_free;
  } oat_stat_t;

endpackage

// File: sv/ordered_assoc_table_core.sv
// Ordered key/value table of DEPTH entries held in two single-port-read memories, one item
// at a time. An out-of-range by-index operation, a full-table add, an add and a rekey by
// index go from dispatch straight to the result, and get by index first reads the value.
// Key operations scan the key memory one entry per cycle through its read port, and get nth
// match then reads the value too. A removal, by key or by index, then copies every following
// entry down one place, one per cycle. A new item is taken while the previous result still
// waits, and a finished result waits in turn until that one has gone.
module ordered_assoc_table_core import oat_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OP_W-1:0]      in_op,
  input  logic [KEY_W-1:0]     in_key_hash,
  input  logic [KEY_W-1:0]     in_new_key_hash,
  input  logic [VAL_W-1:0]     in_value_in,
  input  logic [POS_W-1:0]     in_position,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STAT_W-1:0]    out_status,
  output logic [OUT_IDX_W-1:0] out_index_out,
  output logic [VAL_W-1:0]     out_value_out,
  output logic [OUT_CNT_W-1:0] out_count
);

  oat_cmd_t  cmd;
  oat_stat_t stat;

  // sequencer
  oat_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage, scan and result register
  oat_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_op           (in_op),
    .in_key_hash     (in_key_hash),
    .in_new_key_hash (in_new_key_hash),
    .in_value_in     (in_value_in),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_index_out   (out_index_out),
    .out_value_out   (out_value_out),
    .out_count       (out_count)
  );

`ifndef ASSERT_OFF
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is in progress");

  a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_index_out == '0 && out_value_out == '0))
    else $error("failed result carries index or value");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count <= OUT_CNT_W'(DEPTH)))
    else $error("entry count above depth");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL)) |-> (out_count == OUT_CNT_W'(DEPTH)))
    else $error("table full reported below depth");
`endif

endmodule

// File: sv/oat_datapath.sv
module oat_datapath import oat_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  oat_cmd_t             cmd,
  output oat_stat_t            stat,
  input  logic [OP_W-1:0]      in_op,
  input  logic [KEY_W-1:0]     in_key_hash,
  input  logic [KEY_W-1:0]     in_new_key_hash,
  input  logic [VAL_W-1:0]     in_value_in,
  input  logic [POS_W-1:0]     in_position,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STAT_W-1:0]    out_status,
  output logic [OUT_IDX_W-1:0] out_index_out,
  output logic [VAL_W-1:0]     out_value_out,
  output logic [OUT_CNT_W-1:0] out_count
);

  // latched item
  op_t              op_r;
  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] nkey_r;
  logic [VAL_W-1:0] val_r;
  logic [POS_W-1:0] pos_r;

  // table control
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic             rd_v_r, rd_v_nxt;
  logic [IDX_W-1:0] cmp_idx_r;
  logic [CNT_W-1:0] seen_r, seen_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;

  // storage
  logic [KEY_W-1:0] key_mem [DEPTH];
  logic [VAL_W-1:0] val_mem [DEPTH];
  logic [KEY_W-1:0] key_rd_r;
  logic [VAL_W-1:0] val_rd_r;

  // result register
  logic                 out_valid_r;
  status_t              out_status_r;
  logic [OUT_IDX_W-1:0] out_index_r;
  logic [VAL_W-1:0]     out_value_r;
  logic [OUT_CNT_W-1:0] out_count_r;

  logic             issue;
  logic             step;
  logic             key_eq;
  logic             nth_ok;
  logic             hit;
  logic             last;
  logic             key_we;
  logic [IDX_W-1:0] key_waddr;
  logic [KEY_W-1:0] key_wdata;
  logic             val_we;
  logic [IDX_W-1:0] val_waddr;
  logic [VAL_W-1:0] val_wdata;
  logic             val_re;
  logic [IDX_W-1:0] val_raddr;
  logic             res_ok;

  // compare of the entry read in the previous cycle
  assign step   = cmd.scan_step | cmd.shift_step;
  assign issue  = ptr_r < count_r;
  assign key_eq = rd_v_r && (key_rd_r == key_r);
  assign nth_ok = CMP_W'(seen_r) == CMP_W'(pos_r);
  assign hit    = key_eq && ((op_r != OP_GET_NTH) || nth_ok);
  assign last   = CNT_W'(cmp_idx_r) == (count_r - CNT_W'(1));

  // status to controller
  always_comb begin
    stat.op         = op_r;
    stat.full       = count_r == CNT_W'(DEPTH);
    stat.empty      = count_r == '0;
    stat.pos_oob    = CMP_W'(pos_r) >= CMP_W'(count_r);
    stat.hit        = hit;
    stat.miss       = rd_v_r && !hit && last;
    stat.shift_done = !issue && !rd_v_r;
    stat.out_free   = !out_valid_r || !out_stall;
  end

  // pointer, counters and hit index
  always_comb begin
    ptr_nxt     = ptr_r;
    rd_v_nxt    = rd_v_r;
    seen_nxt    = seen_r;
    hit_idx_nxt = hit_idx_r;
    count_nxt   = count_r;
    if (cmd.scan_init) begin
      ptr_nxt  = '0;
      rd_v_nxt = 1'b0;
      seen_nxt = '0;
    end
    if (step) begin
      ptr_nxt  = issue ? (ptr_r + CNT_W'(1)) : ptr_r;
      rd_v_nxt = issue;
    end
    if (cmd.scan_step && key_eq && !hit) begin
      seen_nxt = seen_r + CNT_W'(1);
    end
    if (cmd.scan_step && hit) begin
      hit_idx_nxt = cmp_idx_r;
    end
    if (cmd.hit_from_pos) begin
      hit_idx_nxt = IDX_W'(pos_r);
    end
    if (cmd.wr_add) begin
      hit_idx_nxt = IDX_W'(count_r);
      count_nxt   = count_r + CNT_W'(1);
    end
    if (cmd.shift_init) begin
      ptr_nxt  = CNT_W'(hit_idx_nxt) + CNT_W'(1);
      rd_v_nxt = 1'b0;
    end
    if (cmd.dec_count) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // memory write and value read selection
  always_comb begin
    key_we    = 1'b0;
    key_waddr = cmp_idx_r - IDX_W'(1);
    key_wdata = key_rd_r;
    val_we    = 1'b0;
    val_waddr = cmp_idx_r - IDX_W'(1);
    val_wdata = val_rd_r;
    if (cmd.shift_step && rd_v_r) begin
      key_we = 1'b1;
      val_we = 1'b1;
    end
    if (cmd.wr_add) begin
      key_we    = 1'b1;
      key_waddr = IDX_W'(count_r);
      key_wdata = key_r;
      val_we    = 1'b1;
      val_waddr = IDX_W'(count_r);
      val_wdata = val_r;
    end
    if (cmd.wr_key) begin
      key_we    = 1'b1;
      key_waddr = hit_idx_nxt;
      key_wdata = nkey_r;
    end
    val_re    = (cmd.shift_step && issue) || cmd.fetch;
    val_raddr = cmd.fetch ? hit_idx_r : ptr_r[IDX_W-1:0];
  end

  // key memory
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    if (step && issue) begin
      key_rd_r <= key_mem[ptr_r[IDX_W-1:0]];
    end
  end

  // value memory
  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_waddr] <= val_wdata;
    end
    if (val_re) begin
      val_rd_r <= val_mem[val_raddr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rd_v_r  <= 1'b0;
      ptr_r   <= '0;
    end else begin
      count_r <= count_nxt;
      rd_v_r  <= rd_v_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  // item, scan and index registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op_t'(in_op);
      key_r  <= in_key_hash;
      nkey_r <= in_new_key_hash;
      val_r  <= in_value_in;
      pos_r  <= in_position;
    end
    if (step && issue) begin
      cmp_idx_r <= ptr_r[IDX_W-1:0];
    end
    seen_r    <= seen_nxt;
    hit_idx_r <= hit_idx_nxt;
  end

  // result register, cleared once the transfer completes
  assign res_ok = cmd.out_status == ST_OK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_index_r  <= res_ok ? OUT_IDX_W'(hit_idx_r) : '0;
      out_value_r  <= (res_ok && (op_r == OP_GET_NTH || op_r == OP_GET_IDX)) ?
                      val_rd_r : '0;
      out_count_r  <= OUT_CNT_W'(count_r);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_index_out = out_index_r;
  assign out_value_out = out_value_r;
  assign out_count     = out_count_r;

endmodule

// File: sv/oat_ctrl.sv
module oat_ctrl import oat_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  oat_stat_t stat,
  output oat_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DISPATCH = 6'b000010,
    S_SCAN     = 6'b000100,
    S_SHIFT    = 6'b001000,
    S_FETCH    = 6'b010000,
    S_RESP     = 6'b100000
  } state_t;

  state_t  state_r, state_nxt;
  status_t status_r, status_nxt;

  assign in_stall = state_r != S_IDLE;

  // sequencing
  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    cmd        = '0;
    cmd.out_status = status_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.op)
          OP_ADD: begin
            state_nxt = S_RESP;
            if (stat.full) begin
              status_nxt = ST_FULL;
            end else begin
              cmd.wr_add = 1'b1;
              status_nxt = ST_OK;
            end
          end
          OP_FIND, OP_REM_KEY, OP_GET_NTH, OP_REKEY_KEY: begin
            if (stat.empty) begin
              status_nxt = ST_NOT_FOUND;
              state_nxt  = S_RESP;
            end else begin
              cmd.scan_init = 1'b1;
              state_nxt     = S_SCAN;
            end
          end
          default: begin
            // by-index operations
            if (stat.pos_oob) begin
              status_nxt = ST_RANGE;
              state_nxt  = S_RESP;
            end else begin
              cmd.hit_from_pos = 1'b1;
              status_nxt       = ST_OK;
              state_nxt        = S_RESP;
              if (stat.op == OP_REM_IDX) begin
                cmd.shift_init = 1'b1;
                state_nxt      = S_SHIFT;
              end else if (stat.op == OP_GET_IDX) begin
                state_nxt = S_FETCH;
              end else begin
                cmd.wr_key = 1'b1;
              end
            end
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.hit) begin
          status_nxt = ST_OK;
          state_nxt  = S_RESP;
          if (stat.op == OP_REM_KEY) begin
            cmd.shift_init = 1'b1;
            state_nxt      = S_SHIFT;
          end else if (stat.op == OP_GET_NTH) begin
            state_nxt = S_FETCH;
          end else if (stat.op == OP_REKEY_KEY) begin
            cmd.wr_key = 1'b1;
          end
        end else if (stat.miss) begin
          status_nxt = ST_NOT_FOUND;
          state_nxt  = S_RESP;
        end
      end
      S_SHIFT: begin
        // move the following entries down one place
        cmd.shift_step = 1'b1;
        if (stat.shift_done) begin
          cmd.dec_count = 1'b1;
          state_nxt     = S_RESP;
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

// File: tb/sv/ordered_assoc_table_watch.sv
`timescale 1ns / 1ps

module ordered_assoc_table_watch import oat_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [OP_W-1:0]      in_op,
  input  logic [KEY_W-1:0]     in_key_hash,
  input  logic [KEY_W-1:0]     in_new_key_hash,
  input  logic [VAL_W-1:0]     in_value_in,
  input  logic [POS_W-1:0]     in_position,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [STAT_W-1:0]    out_status,
  input  logic [OUT_IDX_W-1:0] out_index_out,
  input  logic [VAL_W-1:0]     out_value_out,
  input  logic [OUT_CNT_W-1:0] out_count,
  output int                   mismatches,
  output int                   awaiting,
  output int                   fill_level
);

  typedef struct {
    status_t              status;
    logic [OUT_IDX_W-1:0] idx;
    logic [VAL_W-1:0]     value;
    logic [OUT_CNT_W-1:0] count;
  } table_result_t;

  // mirror of the table contents
  logic [KEY_W-1:0] key_mirror [DEPTH];
  logic [VAL_W-1:0] val_mirror [DEPTH];
  int               entries = 0;

  table_result_t awaited_results [$];

  initial begin
    mismatches = 0;
    awaiting   = 0;
    fill_level = 0;
  end

  // close the gap left by a removed entry
  function automatic void drop_entry(int at);
    for (int i = at; i + 1 < entries; i++) begin
      key_mirror[i] = key_mirror[i + 1];
      val_mirror[i] = val_mirror[i + 1];
    end
    entries--;
  endfunction

  // work out the result of one table operation and update the mirror
  function automatic table_result_t apply_table_op(op_t op, logic [KEY_W-1:0] key,
                                                   logic [KEY_W-1:0] nkey,
                                                   logic [VAL_W-1:0] val,
                                                   logic [POS_W-1:0] pos);
    table_result_t res;
    int hit;
    int seen;
    res.status = ST_OK;
    res.idx    = '0;
    res.value  = '0;
    case (op)
      OP_ADD: begin
        if (entries >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          res.idx             = OUT_IDX_W'(entries);
          key_mirror[entries] = key;
          val_mirror[entries] = val;
          entries++;
        end
      end
      OP_FIND, OP_REM_KEY, OP_REKEY_KEY: begin
        hit = entries;
        for (int i = entries - 1; i >= 0; i--)
          if (key_mirror[i] == key) hit = i;
        if (hit >= entries) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res.idx = OUT_IDX_W'(hit);
          if (op == OP_REM_KEY) drop_entry(hit);
          else if (op == OP_REKEY_KEY) key_mirror[hit] = nkey;
        end
      end
      OP_GET_NTH: begin
        res.status = ST_NOT_FOUND;
        seen = 0;
        for (int i = 0; i < entries; i++) begin
          if (key_mirror[i] == key) begin
            if (seen == int'(pos)) begin
              res.status = ST_OK;
              res.idx    = OUT_IDX_W'(i);
              res.value  = val_mirror[i];
              break;
            end
            seen++;
          end
        end
      end
      default: begin
        // operations addressed by index
        if (int'(pos) >= entries) begin
          res.status = ST_RANGE;
        end else begin
          res.idx = OUT_IDX_W'(pos);
          if (op == OP_REM_IDX) drop_entry(int'(pos));
          else if (op == OP_GET_IDX) res.value = val_mirror[IDX_W'(pos)];
          else key_mirror[IDX_W'(pos)] = nkey;
        end
      end
    endcase
    res.count = OUT_CNT_W'(entries);
    return res;
  endfunction

  // watch both channels at the rising edge
  always @(posedge clk) begin
    table_result_t want;
    if (!rst_n) begin
      entries = 0;
      awaited_results.delete();
    end else begin
      // result transfer against the oldest expectation
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result: status %0d index %0d value %h count %0d",
                     $time, out_status, out_index_out, out_value_out, out_count);
        end else begin
          want = awaited_results.pop_front();
          if (out_status !== want.status || out_index_out !== want.idx ||
              out_value_out !== want.value || out_count !== want.count) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch: expected status %0d index %0d value %h count %0d,",
                       $time, want.status, want.idx, want.value, want.count);
              $display("  got status %0d index %0d value %h count %0d",
                       out_status, out_index_out, out_value_out, out_count);
            end
          end
        end
      end
      // input transfer
      if (in_valid && !in_stall)
        awaited_results.push_back(apply_table_op(op_t'(in_op), in_key_hash, in_new_key_hash,
                                                 in_value_in, in_position));
    end
    awaiting   = awaited_results.size();
    fill_level = entries;
  end

endmodule

// File: tb/sv/ordered_assoc_table_core_test.sv
`timescale 1ns / 1ps

module ordered_assoc_table_core_test;
  import oat_pkg::*;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} mix_mode_t;

  logic                 clk             = 1'b0;
  logic                 rst_n           = 1'b0;
  logic                 in_valid        = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      in_op           = '0;
  logic [KEY_W-1:0]     in_key_hash     = '0;
  logic [KEY_W-1:0]     in_new_key_hash = '0;
  logic [VAL_W-1:0]     in_value_in     = '0;
  logic [POS_W-1:0]     in_position     = '0;
  logic                 out_valid;
  logic                 out_stall       = 1'b0;
  logic [STAT_W-1:0]    out_status;
  logic [OUT_IDX_W-1:0] out_index_out;
  logic [VAL_W-1:0]     out_value_out;
  logic [OUT_CNT_W-1:0] out_count;

  int mismatches;
  int awaiting;
  int fill_level;

  // idle control shared by both sides
  logic no_idle     = 1'b0;
  int   hold_ask    = 0;
  int   hold_served = 0;

  always #5 clk = ~clk;

  ordered_assoc_table_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_key_hash     (in_key_hash),
    .in_new_key_hash (in_new_key_hash),
    .in_value_in     (in_value_in),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_index_out   (out_index_out),
    .out_value_out   (out_value_out),
    .out_count       (out_count)
  );

  ordered_assoc_table_watch watch (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_key_hash     (in_key_hash),
    .in_new_key_hash (in_new_key_hash),
    .in_value_in     (in_value_in),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_index_out   (out_index_out),
    .out_value_out   (out_value_out),
    .out_count       (out_count),
    .mismatches      (mismatches),
    .awaiting        (awaiting),
    .fill_level      (fill_level)
  );

  // one input transfer, entered and left at a falling edge
  task automatic offer_item(input op_t op, input logic [KEY_W-1:0] key,
                            input logic [KEY_W-1:0] nkey, input logic [VAL_W-1:0] val,
                            input logic [POS_W-1:0] pos);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_op           <= op;
    in_key_hash     <= key;
    in_new_key_hash <= nkey;
    in_value_in     <= val;
    in_position     <= pos;
    in_valid        <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // stop offering until every result is back
  task automatic settle;
    in_valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
  endtask

  // keys from a small pool so that matches and duplicates are common
  function automatic logic [KEY_W-1:0] pool_key();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      8, 9:    return $urandom;
      default: return 32'hA5A5_0000 + $urandom_range(0, 5);
    endcase
  endfunction

  function automatic op_t pick_op(mix_mode_t mode);
    case (mode)
      MODE_FILL:  return ($urandom_range(0, 9) < 8) ? OP_ADD : op_t'($urandom_range(1, 7));
      MODE_DRAIN: begin
        if ($urandom_range(0, 9) < 6)
          return $urandom_range(0, 1) ? OP_REM_KEY : OP_REM_IDX;
        return op_t'($urandom_range(0, 7));
      end
      default:    return op_t'($urandom_range(0, 7));
    endcase
  endfunction

  task automatic issue_random(input mix_mode_t mode);
    op_t              op;
    logic [POS_W-1:0] pos;
    op = pick_op(mode);
    if (op == OP_GET_NTH)
      pos = ($urandom_range(0, 9) < 8) ? POS_W'($urandom_range(0, 3))
                                       : POS_W'($urandom_range(0, 255));
    else
      pos = ($urandom_range(0, 9) < 8) ? POS_W'($urandom_range(0, fill_level + 1))
                                       : POS_W'($urandom_range(0, 255));
    offer_item(op, pool_key(), ($urandom_range(0, 3) == 0) ? $urandom : pool_key(),
               $urandom, pos);
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int gap;
    @(posedge rst_n);
    forever begin
      if (hold_served != hold_ask) begin
        hold_served = hold_ask;
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(negedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    mix_mode_t mode;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table: every miss and range case
    offer_item(OP_FIND,      '0, '0, '0, 8'd0);
    offer_item(OP_REM_KEY,   '1, '0, '0, 8'd0);
    offer_item(OP_REM_IDX,   '0, '0, '0, 8'd0);
    offer_item(OP_GET_NTH,   '0, '0, '0, 8'd0);
    offer_item(OP_GET_IDX,   '0, '0, '0, 8'd255);
    offer_item(OP_REKEY_KEY, '0, '1, '0, 8'd0);
    offer_item(OP_REKEY_IDX, '0, '1, '0, 8'd0);
    // duplicates and extreme keys and values
    offer_item(OP_ADD,       '0, '1, '0, 8'd255);
    offer_item(OP_ADD,       '1, '0, '1, 8'd0);
    offer_item(OP_ADD,       '0, '0, 32'h1234_5678, 8'd0);
    offer_item(OP_FIND,      '0, '0, '0, 8'd0);
    offer_item(OP_GET_NTH,   '0, '0, '0, 8'd1);
    offer_item(OP_GET_NTH,   '0, '0, '0, 8'd2);
    offer_item(OP_GET_NTH,   '0, '0, '0, 8'd255);
    offer_item(OP_GET_IDX,   '0, '0, '0, 8'd1);
    offer_item(OP_GET_IDX,   '0, '0, '0, 8'd3);
    offer_item(OP_REKEY_KEY, '0, 32'h0000_0005, '0, 8'd0);
    offer_item(OP_REKEY_IDX, '0, '0, '0, 8'd1);
    offer_item(OP_REM_KEY,   '0, '0, '0, 8'd0);
    offer_item(OP_REM_IDX,   '0, '0, '0, 8'd0);
    offer_item(OP_GET_IDX,   '0, '0, '0, 8'd0);
    offer_item(OP_REM_IDX,   '0, '0, '0, 8'd1);
    settle();

    // random phases: fill to full, mix, drain to empty
    for (int phase = 0; phase < 10; phase++) begin
      case (phase % 5)
        0, 1:    mode = MODE_FILL;
        3, 4:    mode = MODE_DRAIN;
        default: mode = MODE_MIX;
      endcase
      no_idle = (phase == 3 || phase == 7);
      if (phase == 1) hold_ask++;
      for (int n = 0; n < 60; n++)
        issue_random(mode);
      if (phase % 3 == 2) settle();
    end

    settle();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin : watchdog
    #6_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
